### hdl/cotp_pkg.sv
// Shared types and constants for the transport option TLV parser.
// No dependencies; imported by every module of the block.
package cotp_pkg;

    // Option type codes.
    localparam logic [7:0] OPT_TPDU = 8'hc0;
    localparam logic [7:0] OPT_RSEL = 8'hc1;
    localparam logic [7:0] OPT_LSEL = 8'hc2;
    localparam logic [7:0] OPT_ADD  = 8'hc6;

    // Parser position inside the current option.
    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_VALUE,
        PH_SKIP
    } t_phase;

    // One result item.
    typedef struct packed {
        logic        status;
        logic        size_given;
        logic [7:0]  size_exponent;
        logic [2:0]  remote_sel_len;
        logic [31:0] remote_sel_value;
        logic [2:0]  local_sel_len;
        logic [31:0] local_sel_value;
    } t_result;

endpackage

### hdl/cotp_in_stage.sv
// Input register for option bytes, with the input-side stall.
// Depends on cotp_pkg.
module cotp_in_stage
    import cotp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_stall,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       w_load;

    // The register takes a new item when empty or when its item moves on.
    assign w_load  = !r_valid || i_advance;
    assign o_stall = !w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

### hdl/cotp_parse.sv
// Per-byte TLV state update and formation of the result on the last byte.
// Depends on cotp_pkg.
module cotp_parse
    import cotp_pkg::*;
#(
    parameter int MAX_SEL_BYTES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_result    o_res
);

    localparam logic [7:0] MaxSel = 8'(MAX_SEL_BYTES);

    t_phase      r_phase,      n_phase;
    logic [7:0]  r_cur_type,   n_cur_type;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [2:0]  r_byte_index, n_byte_index;
    logic        r_err,        n_err;
    logic        r_size_seen,  n_size_seen;
    logic [7:0]  r_size_exp,   n_size_exp;
    logic [2:0]  r_rem_len,    n_rem_len;
    logic [31:0] r_rem_val,    n_rem_val;
    logic [2:0]  r_loc_len,    n_loc_len;
    logic [31:0] r_loc_val,    n_loc_val;
    logic [31:0] r_sel_acc,    n_sel_acc;

    logic w_is_sel;
    logic w_commit;

    assign w_is_sel = (r_cur_type == OPT_RSEL) || (r_cur_type == OPT_LSEL);

    // Next state for one accepted byte.
    always_comb begin
        n_phase      = r_phase;
        n_cur_type   = r_cur_type;
        n_bytes_left = r_bytes_left;
        n_byte_index = r_byte_index;
        n_err        = r_err;
        n_size_seen  = r_size_seen;
        n_size_exp   = r_size_exp;
        n_sel_acc    = r_sel_acc;
        w_commit     = 1'b0;
        if (r_err) begin
            n_phase = PH_SKIP;
        end else begin
            unique case (r_phase)
                PH_TYPE: begin
                    n_cur_type = i_byte;
                    n_phase    = PH_LEN;
                end
                PH_LEN: begin
                    n_bytes_left = i_byte;
                    n_byte_index = 3'd0;
                    n_sel_acc    = 32'd0;
                    if ((r_cur_type == OPT_TPDU) || (r_cur_type == OPT_ADD)) begin
                        if (i_byte == 8'd1) begin
                            n_phase = PH_VALUE;
                        end else begin
                            n_err = 1'b1;
                        end
                    end else if (w_is_sel) begin
                        if (i_byte > MaxSel) begin
                            n_err = 1'b1;
                        end else if (i_byte == 8'd0) begin
                            // An empty selector is stored at once.
                            w_commit = 1'b1;
                            n_phase  = PH_TYPE;
                        end else begin
                            n_phase = PH_VALUE;
                        end
                    end else begin
                        n_phase = (i_byte == 8'd0) ? PH_TYPE : PH_VALUE;
                    end
                    if (n_err) begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_VALUE: begin
                    if (r_cur_type == OPT_TPDU) begin
                        n_size_exp  = i_byte;
                        n_size_seen = 1'b1;
                    end else if (w_is_sel) begin
                        // Only the first four selector bytes are visible.
                        if (!r_byte_index[2]) begin
                            n_sel_acc = r_sel_acc |
                                ({24'd0, i_byte} << {r_byte_index[1:0], 3'b000});
                        end
                        n_byte_index = r_byte_index + 3'd1;
                    end
                    n_bytes_left = r_bytes_left - 8'd1;
                    if (n_bytes_left == 8'd0) begin
                        w_commit = w_is_sel;
                        n_phase  = PH_TYPE;
                    end
                end
                PH_SKIP: begin
                    n_phase = PH_SKIP;
                end
                default: begin
                    n_phase = PH_SKIP;
                end
            endcase
        end
        // An area that ends inside an option is cut off.
        if (i_last && (n_phase != PH_TYPE)) begin
            n_err = 1'b1;
        end
    end

    // Selector store: the completed selector replaces the old one.
    always_comb begin
        n_rem_len = r_rem_len;
        n_rem_val = r_rem_val;
        n_loc_len = r_loc_len;
        n_loc_val = r_loc_val;
        if (w_commit) begin
            if (r_cur_type == OPT_RSEL) begin
                n_rem_len = n_byte_index;
                n_rem_val = n_sel_acc;
            end else begin
                n_loc_len = n_byte_index;
                n_loc_val = n_sel_acc;
            end
        end
    end

    // Result fields, taken from the updated state.
    always_comb begin
        o_res.status           = n_err;
        o_res.size_given       = n_size_seen;
        o_res.size_exponent    = n_size_seen ? n_size_exp : 8'd0;
        o_res.remote_sel_len   = n_rem_len;
        o_res.remote_sel_value = n_rem_val;
        o_res.local_sel_len    = n_loc_len;
        o_res.local_sel_value  = n_loc_val;
    end

    // Per-area state clears after the last byte; selectors persist.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TYPE;
            r_cur_type   <= 8'd0;
            r_bytes_left <= 8'd0;
            r_byte_index <= 3'd0;
            r_err        <= 1'b0;
            r_size_seen  <= 1'b0;
            r_size_exp   <= 8'd0;
            r_sel_acc    <= 32'd0;
            r_rem_len    <= 3'd0;
            r_rem_val    <= 32'd0;
            r_loc_len    <= 3'd0;
            r_loc_val    <= 32'd0;
        end else if (i_go) begin
            r_rem_len <= n_rem_len;
            r_rem_val <= n_rem_val;
            r_loc_len <= n_loc_len;
            r_loc_val <= n_loc_val;
            if (i_last) begin
                r_phase      <= PH_TYPE;
                r_cur_type   <= 8'd0;
                r_bytes_left <= 8'd0;
                r_byte_index <= 3'd0;
                r_err        <= 1'b0;
                r_size_seen  <= 1'b0;
                r_size_exp   <= 8'd0;
                r_sel_acc    <= 32'd0;
            end else begin
                r_phase      <= n_phase;
                r_cur_type   <= n_cur_type;
                r_bytes_left <= n_bytes_left;
                r_byte_index <= n_byte_index;
                r_err        <= n_err;
                r_size_seen  <= n_size_seen;
                r_size_exp   <= n_size_exp;
                r_sel_acc    <= n_sel_acc;
            end
        end
    end

endmodule

### hdl/cotp_out_stage.sv
// Result register with the output-side handshake.
// Depends on cotp_pkg.
module cotp_out_stage
    import cotp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Room for a new result when empty or when the current one is taken.
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### hdl/transport_option_tlv_parser_core.sv
// Top level of the transport option TLV parser.
// Depends on cotp_pkg, cotp_in_stage, cotp_parse and cotp_out_stage.
//
// The block takes one option-area byte per cycle and gives one result item
// on each byte flagged as last: the byte waits in the input register, and
// its result goes through the parse logic into the result register.
// Every byte is handled by a single pass through the per-byte state
// update, so a byte can be accepted in every cycle; only a last byte
// waits, and only while the result register holds an item that is
// stalled. Selectors are kept across areas until a new complete one arrives.
module transport_option_tlv_parser_core
    import cotp_pkg::*;
#(
    parameter int MAX_SEL_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_opt_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic        o_size_given,
    output logic [7:0]  o_size_exponent,
    output logic [2:0]  o_remote_sel_len,
    output logic [31:0] o_remote_sel_value,
    output logic [2:0]  o_local_sel_len,
    output logic [31:0] o_local_sel_value
);

    logic       w_s1_valid;
    logic [7:0] w_s1_byte;
    logic       w_s1_last;
    logic       w_out_free;
    logic       w_go;
    t_result    w_res;
    t_result    w_out_res;

    // A byte moves on unless it is a last byte and the result slot is full and stalled.
    assign w_go = w_s1_valid && (!w_s1_last || w_out_free);

    cotp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_byte    (i_opt_byte),
        .i_last    (i_last_byte),
        .o_stall   (o_in_stall),
        .i_advance (w_go),
        .o_valid   (w_s1_valid),
        .o_byte    (w_s1_byte),
        .o_last    (w_s1_last)
    );

    cotp_parse #(
        .MAX_SEL_BYTES (MAX_SEL_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_byte  (w_s1_byte),
        .i_last  (w_s1_last),
        .o_res   (w_res)
    );

    cotp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_go && w_s1_last),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (w_out_res)
    );

    // Result item fields.
    assign o_status           = w_out_res.status;
    assign o_size_given       = w_out_res.size_given;
    assign o_size_exponent    = w_out_res.size_exponent;
    assign o_remote_sel_len   = w_out_res.remote_sel_len;
    assign o_remote_sel_value = w_out_res.remote_sel_value;
    assign o_local_sel_len    = w_out_res.local_sel_len;
    assign o_local_sel_value  = w_out_res.local_sel_value;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for transport_option_tlv_parser_core.
// Depends on cotp_pkg and the parser RTL; predicts each result item from the bytes accepted.
module testbench;
    import cotp_pkg::*;

    localparam int MAX_SEL_BYTES = 4;

    // One byte of an option area as the driver presents it.
    typedef struct {
        logic [7:0] octet;
        logic       last;
    } t_area_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_opt_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_status;
    logic        o_size_given;
    logic [7:0]  o_size_exponent;
    logic [2:0]  o_remote_sel_len;
    logic [31:0] o_remote_sel_value;
    logic [2:0]  o_local_sel_len;
    logic [31:0] o_local_sel_value;

    t_area_byte  byte_queue[$];
    t_result     area_results_due[$];
    t_area_byte  next_byte;
    t_result     due;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int          mismatches = 0;

    // Parser state as predicted from the accepted bytes.
    t_phase      ph = PH_TYPE;
    logic [7:0]  opt_type = '0;
    logic [7:0]  remaining = '0;
    logic [2:0]  sel_count = '0;
    logic [31:0] sel_bytes = '0;
    logic        err_seen = 1'b0;
    logic        tpdu_seen = 1'b0;
    logic [7:0]  tpdu_exp = '0;
    logic [2:0]  rsel_len = '0;
    logic [31:0] rsel_val = '0;
    logic [2:0]  lsel_len = '0;
    logic [31:0] lsel_val = '0;

    transport_option_tlv_parser_core #(
        .MAX_SEL_BYTES(MAX_SEL_BYTES)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opt_byte         (i_opt_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_size_given       (o_size_given),
        .o_size_exponent    (o_size_exponent),
        .o_remote_sel_len   (o_remote_sel_len),
        .o_remote_sel_value (o_remote_sel_value),
        .o_local_sel_len    (o_local_sel_len),
        .o_local_sel_value  (o_local_sel_value)
    );

    always #1 i_clk = ~i_clk;

    // Replace the selector named by the current option type.
    task automatic store_selector(input logic [2:0] len);
        if (opt_type == OPT_RSEL) begin
            rsel_len = len;
            rsel_val = sel_bytes;
        end else begin
            lsel_len = len;
            lsel_val = sel_bytes;
        end
    endtask

    // Advance the predicted parser by one accepted byte; on a last byte,
    // queue the result item it must produce and start a fresh area.
    task automatic parse_option_byte(input logic [7:0] b, input logic last);
        t_result res;
        logic    sel_opt;
        sel_opt = (opt_type == OPT_RSEL) || (opt_type == OPT_LSEL);
        if (err_seen) begin
            ph = PH_SKIP;
        end else begin
            case (ph)
                PH_TYPE: begin
                    opt_type = b;
                    ph = PH_LEN;
                end
                PH_LEN: begin
                    remaining = b;
                    sel_count = '0;
                    sel_bytes = '0;
                    if (opt_type == OPT_TPDU || opt_type == OPT_ADD) begin
                        if (b == 8'd1) ph = PH_VALUE;
                        else err_seen = 1'b1;
                    end else if (sel_opt) begin
                        if (b > MAX_SEL_BYTES) begin
                            err_seen = 1'b1;
                        end else if (b == 8'd0) begin
                            // An empty selector takes effect at its length byte.
                            store_selector(3'd0);
                            ph = PH_TYPE;
                        end else begin
                            ph = PH_VALUE;
                        end
                    end else begin
                        ph = (b == 8'd0) ? PH_TYPE : PH_VALUE;
                    end
                    if (err_seen) ph = PH_SKIP;
                end
                PH_VALUE: begin
                    if (opt_type == OPT_TPDU) begin
                        tpdu_exp = b;
                        tpdu_seen = 1'b1;
                    end else if (sel_opt) begin
                        sel_bytes[8*sel_count +: 8] = b;
                        sel_count = sel_count + 3'd1;
                    end
                    remaining = remaining - 8'd1;
                    if (remaining == 8'd0) begin
                        if (sel_opt) store_selector(sel_count);
                        ph = PH_TYPE;
                    end
                end
                default: ph = PH_SKIP;
            endcase
        end

        if (last) begin
            // An area that ends inside an option is cut off.
            if (ph != PH_TYPE) err_seen = 1'b1;
            res.status = err_seen;
            res.size_given = tpdu_seen;
            res.size_exponent = tpdu_seen ? tpdu_exp : 8'd0;
            res.remote_sel_len = rsel_len;
            res.remote_sel_value = rsel_val;
            res.local_sel_len = lsel_len;
            res.local_sel_value = lsel_val;
            area_results_due.push_back(res);
            ph = PH_TYPE;
            opt_type = '0;
            remaining = '0;
            sel_count = '0;
            sel_bytes = '0;
            err_seen = 1'b0;
            tpdu_seen = 1'b0;
            tpdu_exp = '0;
        end
    endtask

    // Idle length for either side: mostly none or short, a few long, and
    // none at all during recurring quiet stretches.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (cycle_count % 1200 < 200) return 0;
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Queue a directed area given as bytes, first byte in the top octet.
    task automatic push_area(input logic [8*16-1:0] bytes, input int count);
        t_area_byte ab;
        for (int i = 0; i < count; i++) begin
            ab.octet = bytes[8*(count-1-i) +: 8];
            ab.last = (i == count - 1);
            byte_queue.push_back(ab);
        end
    endtask

    // Queue one random area: mostly well-formed options with random values,
    // some with bad lengths or cut short, and some plain noise.
    task automatic add_random_area();
        logic [7:0]  area[$];
        logic [7:0]  code;
        t_area_byte  ab;
        int unsigned flavor;
        int unsigned len;
        int unsigned n_value;
        int unsigned keep;
        flavor = $urandom_range(0, 99);
        if (flavor < 8) begin
            repeat ($urandom_range(1, 12)) area.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 4)) begin
                case ($urandom_range(0, 5))
                    0: code = OPT_TPDU;
                    1: code = OPT_RSEL;
                    2: code = OPT_LSEL;
                    3: code = OPT_ADD;
                    default: code = 8'($urandom_range(0, 255));
                endcase
                if (code == OPT_TPDU || code == OPT_ADD) len = 1;
                else if (code == OPT_RSEL || code == OPT_LSEL)
                    len = $urandom_range(0, MAX_SEL_BYTES);
                else if ($urandom_range(0, 9) == 0) len = $urandom_range(7, 40);
                else len = $urandom_range(0, 6);
                if (flavor < 20 && $urandom_range(0, 2) == 0) begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 8);
                end
                area.push_back(code);
                area.push_back(len[7:0]);
                // A huge length is left unfinished rather than sent in full.
                n_value = (len > 40) ? $urandom_range(0, 5) : len;
                repeat (n_value) area.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (area.size() == 0) area.push_back(8'($urandom_range(0, 255)));
        keep = area.size();
        if (flavor < 20 && keep > 1 && $urandom_range(0, 1) == 0)
            keep = $urandom_range(1, keep - 1);
        for (int i = 0; i < keep; i++) begin
            ab.octet = area[i];
            ab.last = (i == keep - 1);
            byte_queue.push_back(ab);
        end
    endtask

    // Compare one result field and count a mismatch.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: presents queued bytes, holds them while stalled, and feeds
    // each accepted byte to the predictor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) parse_option_byte(i_opt_byte, i_last_byte);
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap != 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    next_byte = byte_queue.pop_front();
                    i_opt_byte <= next_byte.octet;
                    i_last_byte <= next_byte.last;
                    i_in_valid <= 1'b1;
                    send_gap = idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result item against the oldest
    // prediction and stalls the result side at random.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (area_results_due.size() == 0) begin
                    $error("result item arrived with none expected");
                    mismatches++;
                end else begin
                    due = area_results_due.pop_front();
                    check_field("status", 32'(due.status), 32'(o_status));
                    check_field("size_given", 32'(due.size_given), 32'(o_size_given));
                    check_field("size_exponent", 32'(due.size_exponent),
                                32'(o_size_exponent));
                    check_field("remote_sel_len", 32'(due.remote_sel_len),
                                32'(o_remote_sel_len));
                    check_field("remote_sel_value", due.remote_sel_value,
                                o_remote_sel_value);
                    check_field("local_sel_len", 32'(due.local_sel_len),
                                32'(o_local_sel_len));
                    check_field("local_sel_value", due.local_sel_value,
                                o_local_sel_value);
                end
            end
            if (stall_left != 0) begin
                stall_left = stall_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if ($urandom_range(0, 2) == 0) stall_left = idle_len();
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        // Size option at the top exponent, a full remote selector holding
        // both byte extremes, and a two-byte local selector.
        push_area(128'({OPT_TPDU, 8'h01, 8'hff, OPT_RSEL, 8'h04, 8'h00, 8'hff, 8'ha5,
                        8'h5a, OPT_LSEL, 8'h02, 8'h12, 8'h34}), 13);
        // The skipped 0xc6 option, an empty remote selector and an empty
        // unknown option.
        push_area(128'({OPT_ADD, 8'h01, 8'h00, OPT_RSEL, 8'h00, 8'h7f, 8'h00}), 7);
        // Bad length on the size option.
        push_area(128'({OPT_TPDU, 8'h02}), 2);
        // Selector value cut off by the end of the area.
        push_area(128'({OPT_LSEL, 8'h03, 8'h11}), 3);
        // Area ending right after a type byte.
        push_area(128'(OPT_TPDU), 1);
        while (byte_queue.size() < 2026) add_random_area();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_queue.size() != 0 || i_in_valid || area_results_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && area_results_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hang guard.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
